[rtl/assert_macros.svh]
// assertion macros used by the classifier top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define ASSERT_HOLDS(label, clock, rst_n, prop, msg) \
	label: assert property (@(posedge clock) disable iff (!rst_n) (prop)) else $error(msg);

// antecedent in one cycle implies consequent in the same cycle
`define ASSERT_IMPLIES(label, clock, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clock) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// antecedent in one cycle implies consequent in the next cycle
`define ASSERT_NEXT(label, clock, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clock) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/bpc_pkg.sv]
// types and constants of the button press classifier
package bpc_pkg;

	localparam int TIME_W   = 32;
	localparam int SHORT_W  = 16;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 32;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DOUBLE_WIN = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FOCUS_DUR = 3'd3;

	// register reset values
	localparam logic [SHORT_W-1:0] DEBOUNCE_RST   = 16'd25;
	localparam logic [SHORT_W-1:0] DOUBLE_WIN_RST = 16'd350;
	localparam logic [SHORT_W-1:0] LONG_PRESS_RST = 16'd800;
	localparam logic [TIME_W-1:0]  FOCUS_DUR_RST  = 32'd300000;

	// event codes
	localparam logic [1:0] EV_NONE   = 2'd0;
	localparam logic [1:0] EV_SHORT  = 2'd1;
	localparam logic [1:0] EV_DOUBLE = 2'd2;
	localparam logic [1:0] EV_LONG   = 2'd3;

	typedef struct packed {
		logic [1:0] event_kind;
		logic       button_held;
		logic [1:0] view_mode;
		logic       focus_active;
	} result_t;

endpackage

[rtl/bpc_if.sv]
// stream interfaces for button samples and classifier results
interface bpc_sample_if;
	logic                      valid;
	logic                      ready;
	logic                      raw_level;
	logic [bpc_pkg::TIME_W-1:0] now_ms;

	modport source (output valid, output raw_level, output now_ms, input ready);
	modport sink (input valid, input raw_level, input now_ms, output ready);
endinterface

interface bpc_result_if;
	logic       valid;
	logic       ready;
	logic [1:0] event_kind;
	logic       button_held;
	logic [1:0] view_mode;
	logic       focus_active;

	modport source (output valid, output event_kind, output button_held, output view_mode,
		output focus_active, input ready);
	modport sink (input valid, input event_kind, input button_held, input view_mode,
		input focus_active, output ready);
endinterface

[rtl/bpc_core.sv]
// debounce and press classification state with its per-sample update
module bpc_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [bpc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [bpc_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                          step,
	input  logic                          raw_level,
	input  logic [bpc_pkg::TIME_W-1:0]     now_ms,
	output bpc_pkg::result_t              res
);
	import bpc_pkg::*;

	logic [SHORT_W-1:0] debounce_q, double_win_q, long_press_q;
	logic [TIME_W-1:0]  focus_dur_q;

	logic              raw_seen_q, stable_q, long_done_q, pending_q, focus_q;
	logic [TIME_W-1:0] change_time_q, press_time_q, click_time_q, deadline_q;
	logic [1:0]        view_q;

	logic              stable_d, long_done_d, pending_d, focus_d;
	logic [TIME_W-1:0] change_time_d, press_time_d, click_time_d, deadline_d;
	logic [1:0]        view_d, ev;
	logic              level_change;

	always_comb begin
		change_time_d = (raw_level != raw_seen_q) ? now_ms : change_time_q;
		stable_d      = stable_q;
		press_time_d  = press_time_q;
		long_done_d   = long_done_q;
		pending_d     = pending_q;
		click_time_d  = click_time_q;
		view_d        = view_q;
		focus_d       = focus_q;
		deadline_d    = deadline_q;
		ev            = EV_NONE;

		level_change = ((now_ms - change_time_d) >= {16'd0, debounce_q}) &&
			(raw_level != stable_q);
		if (level_change) begin
			stable_d = raw_level;
			if (!raw_level) begin
				press_time_d = now_ms;
				long_done_d  = 1'b0;
			end else if (!long_done_q) begin
				if (pending_q && ((now_ms - click_time_q) <= {16'd0, double_win_q})) begin
					pending_d = 1'b0;
					ev        = EV_DOUBLE;
				end else begin
					pending_d    = 1'b1;
					click_time_d = now_ms;
				end
			end
		end

		if (!long_done_d && !stable_d &&
			((now_ms - press_time_d) >= {16'd0, long_press_q})) begin
			long_done_d = 1'b1;
			pending_d   = 1'b0;
			focus_d     = !focus_q;
			deadline_d  = focus_d ? (now_ms + focus_dur_q) : '0;
			ev          = EV_LONG;
		end

		// a click that starts now has a zero gap, so it cannot expire here
		if (pending_d && ((now_ms - click_time_d) > {16'd0, double_win_q})) begin
			pending_d = 1'b0;
			view_d    = view_q + 2'd1;
			ev        = EV_SHORT;
		end

		// plain unsigned compare, a wrapped deadline expires at once
		if (focus_d && (now_ms >= deadline_d)) begin
			focus_d    = 1'b0;
			deadline_d = '0;
		end

		res.event_kind   = ev;
		res.button_held  = !stable_d;
		res.view_mode    = view_d;
		res.focus_active = focus_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q   <= DEBOUNCE_RST;
			double_win_q <= DOUBLE_WIN_RST;
			long_press_q <= LONG_PRESS_RST;
			focus_dur_q  <= FOCUS_DUR_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_DEBOUNCE:   debounce_q   <= cfg_data[SHORT_W-1:0];
				REG_DOUBLE_WIN: double_win_q <= cfg_data[SHORT_W-1:0];
				REG_LONG_PRESS: long_press_q <= cfg_data[SHORT_W-1:0];
				REG_FOCUS_DUR:  focus_dur_q  <= cfg_data[TIME_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			raw_seen_q    <= 1'b1;
			stable_q      <= 1'b1;
			change_time_q <= '0;
			press_time_q  <= '0;
			long_done_q   <= 1'b0;
			pending_q     <= 1'b0;
			click_time_q  <= '0;
			view_q        <= '0;
			focus_q       <= 1'b0;
			deadline_q    <= '0;
		end else if (step) begin
			raw_seen_q    <= raw_level;
			stable_q      <= stable_d;
			change_time_q <= change_time_d;
			press_time_q  <= press_time_d;
			long_done_q   <= long_done_d;
			pending_q     <= pending_d;
			click_time_q  <= click_time_d;
			view_q        <= view_d;
			focus_q       <= focus_d;
			deadline_q    <= deadline_d;
		end
	end

endmodule

[rtl/bpc_out_buf.sv]
// result register with a skid slot; in_ready drops only once the skid slot is full
module bpc_out_buf (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  bpc_pkg::result_t    in_data,
	bpc_result_if.source        result
);
	import bpc_pkg::*;

	logic    out_valid_q, skid_valid_q;
	result_t out_data_q, skid_data_q;

	assign in_ready = !skid_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || result.ready) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= in_valid;
			end
		end else if (in_valid && in_ready) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || result.ready) begin
			out_data_q <= skid_valid_q ? skid_data_q : in_data;
		end else if (in_valid && in_ready) begin
			skid_data_q <= in_data;
		end
	end

	assign result.valid        = out_valid_q;
	assign result.event_kind   = out_data_q.event_kind;
	assign result.button_held  = out_data_q.button_held;
	assign result.view_mode    = out_data_q.view_mode;
	assign result.focus_active = out_data_q.focus_active;

endmodule

[rtl/button_press_classifier_unit.sv]
// top level of the button press classifier
//
// sample channel: one beat per poll of the active-low pin, raw_level plus a
// millisecond timestamp now_ms. result channel: exactly one beat per sample
// with the event code (none, short, double, long), the debounced held level,
// the view mode and the focus flag.
// a sample beat lands in an input register; once the output buffer has room the
// classifier state is updated from it and the result is written to the output
// register, which offers it on the result channel.
// throughput is one sample per cycle while the receiver does not stall, set by
// the single state update of the classifier, which reads the state left by the
// previous sample.
// configuration is a plain write port: cfg_we, cfg_index (0 debounce,
// 1 double window, 2 long press, 3 focus duration), cfg_data; other indexes
// are ignored. write only while no sample is in flight.
// reset returns registers to their defaults (25, 350, 800, 300000 ms) and the
// classifier to released, idle, view 0, focus off. no clearing pass.
// on a receiver stall results fill the output register and one skid slot;
// sample ready drops once those and the input register are all full.
module button_press_classifier_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [bpc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [bpc_pkg::CFG_DATA_W-1:0] cfg_data,
	bpc_sample_if.sink                    sample,
	bpc_result_if.source                  result
);
	import bpc_pkg::*;
	`include "assert_macros.svh"

	logic              valid_s1;
	logic              raw_s1;
	logic [TIME_W-1:0] now_s1;
	logic              buf_ready;
	logic              advance;
	result_t           core_res;

	assign advance      = valid_s1 && buf_ready;
	assign sample.ready = !valid_s1 || buf_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample.ready) begin
			valid_s1 <= sample.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample.valid && sample.ready) begin
			raw_s1 <= sample.raw_level;
			now_s1 <= sample.now_ms;
		end
	end

	bpc_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.step      (advance),
		.raw_level (raw_s1),
		.now_ms    (now_s1),
		.res       (core_res)
	);

	bpc_out_buf u_out_buf (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (advance),
		.in_ready (buf_ready),
		.in_data  (core_res),
		.result   (result)
	);

	// a full skid slot means the output register holds a beat too
	`ASSERT_IMPLIES(a_skid_implies_out, clk, arst_n, !buf_ready, result.valid,
		"skid slot full with empty output register")
	// an accepted sample is in the input stage next cycle
	`ASSERT_NEXT(a_sample_lands, clk, arst_n, sample.valid && sample.ready, valid_s1,
		"accepted sample beat lost before the input stage")
	// a long press only fires while the button is held
	`ASSERT_IMPLIES(a_long_held, clk, arst_n, advance && core_res.event_kind == EV_LONG,
		core_res.button_held, "long press reported while released")
	// a double press only fires on a release
	`ASSERT_IMPLIES(a_double_released, clk, arst_n,
		advance && core_res.event_kind == EV_DOUBLE, !core_res.button_held,
		"double press reported while held")

endmodule

[tb/sv/tb_top.sv]
// self-checking testbench for button_press_classifier_unit: directed table, then random gestures
module tb_top;
	import bpc_pkg::*;

	localparam int CLK_HALF    = 2;
	localparam int CYCLE_LIMIT = 400000;
	localparam int POLL_TARGET = 950;
	localparam int MAX_REPORTS = 10;
	localparam int N_PRESETS   = 7;
	localparam int RANDOM_PRESET = 4;
	localparam int N_ROWS      = 26;

	typedef struct packed {
		logic              raw;
		logic [TIME_W-1:0] now;
		logic              typed;
		result_t           want;
	} poll_row_t;

	// reset thresholds: debounce 25, double window 350, long press 800, focus 300000
	localparam poll_row_t DIRECTED_POLLS [N_ROWS] = '{
		'{1'b1, 32'd0,    1'b1, '{EV_NONE,   1'b0, 2'd0, 1'b0}},
		'{1'b0, 32'd100,  1'b1, '{EV_NONE,   1'b0, 2'd0, 1'b0}},
		'{1'b0, 32'd130,  1'b1, '{EV_NONE,   1'b1, 2'd0, 1'b0}},
		'{1'b1, 32'd200,  1'b1, '{EV_NONE,   1'b1, 2'd0, 1'b0}},
		'{1'b1, 32'd230,  1'b1, '{EV_NONE,   1'b0, 2'd0, 1'b0}},
		'{1'b0, 32'd300,  1'b0, '0},
		'{1'b0, 32'd330,  1'b0, '0},
		'{1'b1, 32'd400,  1'b0, '0},
		'{1'b1, 32'd430,  1'b1, '{EV_DOUBLE, 1'b0, 2'd0, 1'b0}},
		'{1'b0, 32'd1000, 1'b0, '0},
		'{1'b0, 32'd1030, 1'b0, '0},
		'{1'b1, 32'd1100, 1'b0, '0},
		'{1'b1, 32'd1130, 1'b0, '0},
		'{1'b1, 32'd1481, 1'b1, '{EV_SHORT,  1'b0, 2'd1, 1'b0}},
		'{1'b0, 32'd2000, 1'b0, '0},
		'{1'b0, 32'd2030, 1'b0, '0},
		'{1'b0, 32'd2830, 1'b1, '{EV_LONG,   1'b1, 2'd1, 1'b1}},
		'{1'b1, 32'd2900, 1'b0, '0},
		'{1'b1, 32'd2930, 1'b0, '0},
		'{1'b0, 32'd3000, 1'b0, '0},
		'{1'b0, 32'd3030, 1'b0, '0},
		'{1'b0, 32'd3830, 1'b1, '{EV_LONG,   1'b1, 2'd1, 1'b0}},
		'{1'b1, 32'd3900, 1'b0, '0},
		'{1'b1, 32'd3930, 1'b0, '0},
		'{1'b0, 32'hFFFF_FFFF, 1'b0, '0},
		'{1'b0, 32'd24,   1'b0, '0}
	};

	// debounce, double window, long press, focus duration
	localparam logic [TIME_W-1:0] PRESETS [N_PRESETS][4] = '{
		'{32'd0,     32'd0,     32'd0,     32'd0},
		'{32'd65535, 32'd65535, 32'd65535, 32'hFFFF_FFFF},
		'{32'd25,    32'd350,   32'd800,   32'd300000},
		'{32'd5,     32'd40,    32'd100,   32'd300},
		'{32'd0,     32'd0,     32'd0,     32'd0},
		'{32'd1,     32'd1,     32'd1,     32'd1},
		'{32'd3,     32'd20,    32'd60,    32'd500}
	};

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	bpc_sample_if sample_ch ();
	bpc_result_if result_ch ();

	button_press_classifier_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.sample    (sample_ch),
		.result    (result_ch)
	);

	// classifier state mirrored by the predictor
	logic [TIME_W-1:0] cfg_debounce, cfg_window, cfg_long, cfg_focus_dur;
	bit                seen_level, steady_level, long_fired, click_armed, focus_on;
	logic [TIME_W-1:0] edge_ms, press_ms, click_ms, focus_until;
	logic [1:0]        view_q;

	result_t           poll_results_q [$];
	int                polls_sent, results_seen, mismatches;
	int                n_short, n_double, n_long;
	logic [TIME_W-1:0] stamp;
	bit                tx_quiet;

	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	function automatic result_t classify_poll(input logic raw, input logic [TIME_W-1:0] now);
		result_t    r;
		logic [1:0] ev;
		ev = EV_NONE;
		if (raw != seen_level) begin
			seen_level = raw;
			edge_ms = now;
		end
		if (TIME_W'(now - edge_ms) >= cfg_debounce && raw != steady_level) begin
			steady_level = raw;
			if (!steady_level) begin
				press_ms = now;
				long_fired = 1'b0;
			end else if (!long_fired) begin
				if (click_armed && TIME_W'(now - click_ms) <= cfg_window) begin
					click_armed = 1'b0;
					ev = EV_DOUBLE;
				end else begin
					click_armed = 1'b1;
					click_ms = now;
				end
			end
		end
		if (!long_fired && !steady_level && TIME_W'(now - press_ms) >= cfg_long) begin
			long_fired = 1'b1;
			click_armed = 1'b0;
			focus_on = !focus_on;
			focus_until = focus_on ? TIME_W'(now + cfg_focus_dur) : '0;
			ev = EV_LONG;
		end
		if (click_armed && TIME_W'(now - click_ms) > cfg_window) begin
			click_armed = 1'b0;
			view_q = view_q + 2'd1;
			ev = EV_SHORT;
		end
		// plain unsigned compare, so a wrapped deadline expires at once
		if (focus_on && now >= focus_until) begin
			focus_on = 1'b0;
			focus_until = '0;
		end
		r.event_kind = ev;
		r.button_held = !steady_level;
		r.view_mode = view_q;
		r.focus_active = focus_on;
		return r;
	endfunction

	function automatic int idle_len(input bit quiet);
		int r;
		if (quiet) return 0;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic logic [TIME_W-1:0] around(input logic [TIME_W-1:0] x);
		case ($urandom_range(0, 3))
			0: return (x == 0) ? x : x - 1;
			1: return x;
			2: return x + 1;
			default: return $urandom_range(0, 2 * x + 2);
		endcase
	endfunction

	function automatic logic [TIME_W-1:0] below(input logic [TIME_W-1:0] x);
		return (x == 0) ? '0 : $urandom_range(0, x - 1);
	endfunction

	task automatic flag_mismatch(input string msg);
		mismatches++;
		if (mismatches <= MAX_REPORTS)
			$display("%s", msg);
	endtask

	// called on a falling edge; the write lands at the next rising edge
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		@(negedge clk);
		cfg_we = 1'b0;
		case (idx)
			REG_DEBOUNCE:   cfg_debounce = {16'b0, data[15:0]};
			REG_DOUBLE_WIN: cfg_window = {16'b0, data[15:0]};
			REG_LONG_PRESS: cfg_long = {16'b0, data[15:0]};
			REG_FOCUS_DUR:  cfg_focus_dur = data;
			default: ;
		endcase
	endtask

	task automatic apply_preset(input int p);
		logic [TIME_W-1:0] v [4];
		for (int i = 0; i < 4; i++)
			v[i] = PRESETS[p][i];
		if (p == RANDOM_PRESET) begin
			v[0] = $urandom_range(0, 60);
			v[1] = $urandom_range(0, 500);
			v[2] = $urandom_range(0, 1500);
			v[3] = $urandom_range(0, 5000);
		end
		// upper bits of the 16-bit registers carry junk that must be dropped
		write_reg(REG_DEBOUNCE, {16'($urandom), v[0][15:0]});
		write_reg(REG_DOUBLE_WIN, {16'($urandom), v[1][15:0]});
		write_reg(REG_LONG_PRESS, {16'($urandom), v[2][15:0]});
		write_reg(REG_FOCUS_DUR, v[3]);
		write_reg(REG_FOCUS_DUR + CFG_IDX_W'($urandom_range(1, 4)), $urandom);
	endtask

	task automatic wait_idle();
		sample_ch.valid = 1'b0;
		while (poll_results_q.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic send_poll(input logic raw, input logic [TIME_W-1:0] now, input logic typed,
		input result_t want);
		int      gap;
		result_t predicted;
		gap = idle_len(tx_quiet);
		if (gap > 0) begin
			sample_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		sample_ch.valid = 1'b1;
		sample_ch.raw_level = raw;
		sample_ch.now_ms = now;
		@(posedge clk);
		while (!sample_ch.ready)
			@(posedge clk);
		predicted = classify_poll(raw, now);
		poll_results_q.push_back(typed ? want : predicted);
		polls_sent++;
		if ($urandom_range(0, 49) == 0)
			tx_quiet = !tx_quiet;
		@(negedge clk);
	endtask

	task automatic poll(input logic raw, input logic [TIME_W-1:0] dt);
		stamp = stamp + dt;
		send_poll(raw, stamp, 1'b0, '0);
	endtask

	// contact bounce shorter than the debounce time
	task automatic chatter();
		repeat ($urandom_range(0, 3))
			poll(1'($urandom_range(0, 1)), below(cfg_debounce));
	endtask

	task automatic settle(input logic level);
		poll(level, $urandom_range(0, 3));
		poll(level, around(cfg_debounce));
	endtask

	task automatic stay(input logic level, input logic [TIME_W-1:0] span);
		poll(level, span / 2);
		poll(level, span - span / 2);
	endtask

	task automatic click(input logic [TIME_W-1:0] hold, input logic [TIME_W-1:0] rest);
		chatter();
		settle(1'b0);
		stay(1'b0, hold);
		chatter();
		settle(1'b1);
		stay(1'b1, rest);
	endtask

	task automatic gesture();
		int r;
		r = $urandom_range(0, 99);
		if (r < 30) begin
			click(below(cfg_long), around(cfg_window));
		end else if (r < 55) begin
			click(below(cfg_long), below(cfg_window / 2 + 1));
			click(below(cfg_long / 4 + 1), around(cfg_window));
		end else if (r < 75) begin
			click(around(cfg_long), around(cfg_window));
		end else if (r < 88) begin
			repeat ($urandom_range(1, 4))
				poll(1'b1, around(cfg_window));
		end else begin
			repeat ($urandom_range(1, 6))
				poll(1'($urandom_range(0, 1)),
					($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 3));
		end
	endtask

	initial begin : rx_stall
		int stall_left;
		bit rx_quiet;
		stall_left = 0;
		rx_quiet = 1'b0;
		result_ch.ready = 1'b1;
		forever begin
			@(negedge clk);
			if ($urandom_range(0, 63) == 0)
				rx_quiet = !rx_quiet;
			if (stall_left > 0) begin
				result_ch.ready = 1'b0;
				stall_left--;
			end else begin
				result_ch.ready = 1'b1;
				if (!rx_quiet && $urandom_range(0, 99) < 20)
					stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40)
						: $urandom_range(1, 3);
			end
		end
	end

	always @(posedge clk) begin : result_check
		result_t seen;
		result_t want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			seen = '{result_ch.event_kind, result_ch.button_held, result_ch.view_mode,
				result_ch.focus_active};
			results_seen++;
			case (seen.event_kind)
				EV_SHORT:  n_short++;
				EV_DOUBLE: n_double++;
				EV_LONG:   n_long++;
				default: ;
			endcase
			if (poll_results_q.size() == 0) begin
				flag_mismatch($sformatf("result beat %0d arrived with no poll outstanding",
					results_seen));
			end else begin
				want = poll_results_q.pop_front();
				if (seen.event_kind !== want.event_kind || seen.button_held !== want.button_held
					|| seen.view_mode !== want.view_mode
					|| seen.focus_active !== want.focus_active)
					flag_mismatch($sformatf(
						"beat %0d: kind %0d/%0d held %0d/%0d view %0d/%0d focus %0d/%0d (got/exp)",
						results_seen, seen.event_kind, want.event_kind, seen.button_held,
						want.button_held, seen.view_mode, want.view_mode, seen.focus_active,
						want.focus_active));
			end
		end
	end

	initial begin : watchdog
		int cycles;
		cycles = 0;
		while (cycles <= CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("timeout after %0d cycles with %0d results outstanding", cycles,
			poll_results_q.size());
		$display("*** FAILED ***");
		$finish;
	end

	initial begin : stimulus
		int phase_end;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_DEBOUNCE;
		cfg_data = '0;
		sample_ch.valid = 1'b0;
		sample_ch.raw_level = 1'b1;
		sample_ch.now_ms = '0;
		cfg_debounce = {16'b0, DEBOUNCE_RST};
		cfg_window = {16'b0, DOUBLE_WIN_RST};
		cfg_long = {16'b0, LONG_PRESS_RST};
		cfg_focus_dur = FOCUS_DUR_RST;
		seen_level = 1'b1;
		steady_level = 1'b1;
		long_fired = 1'b0;
		click_armed = 1'b0;
		focus_on = 1'b0;
		edge_ms = '0;
		press_ms = '0;
		click_ms = '0;
		focus_until = '0;
		view_q = '0;
		polls_sent = 0;
		results_seen = 0;
		mismatches = 0;
		n_short = 0;
		n_double = 0;
		n_long = 0;
		tx_quiet = 1'b0;
		stamp = '0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		for (int i = 0; i < N_ROWS; i++)
			send_poll(DIRECTED_POLLS[i].raw, DIRECTED_POLLS[i].now, DIRECTED_POLLS[i].typed,
				DIRECTED_POLLS[i].want);
		stamp = DIRECTED_POLLS[N_ROWS-1].now;

		// each register setting starts from an idle block, so the sender drains first
		for (int p = 0; p < N_PRESETS; p++) begin
			wait_idle();
			apply_preset(p);
			if (p == 1)
				stamp = $urandom;
			else if (p == N_PRESETS - 1)
				stamp = 32'hFFFF_FFFF - $urandom_range(0, 2000);
			phase_end = polls_sent + (POLL_TARGET - N_ROWS) / N_PRESETS;
			while (polls_sent < phase_end)
				gesture();
		end
		wait_idle();

		$display("%0d polls under %0d register settings incl. zero and full-scale thresholds",
			polls_sent, N_PRESETS + 1);
		$display("events seen: %0d short, %0d double, %0d long; %0d mismatching beats",
			n_short, n_double, n_long, mismatches);
		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
